### hw/rtl/ctuv_pkg.sv
// Package for the color temperature to CIE 1960 (u, v) converter.
// Holds the field widths, the scaled rational-approximation coefficients and the divider lane type.
// Used by ctuv_poly, ctuv_div_step and color_temperature_to_uv.
package ctuv_pkg;

    // Field and datapath widths.
    localparam int KW  = 14;   // kelvin input
    localparam int CW  = 20;   // coordinate output
    localparam int DW  = 61;   // numerator, denominator and remainder
    localparam int C2W = 33;   // quadratic coefficients
    localparam int C1W = 43;   // linear coefficients
    localparam int AW  = 48;   // first Horner step
    localparam int PW  = 62;   // second Horner step before truncation

    localparam logic [KW-1:0] KELVIN_MIN = 14'd1000;
    localparam logic [KW-1:0] KELVIN_MAX = 14'd15000;

    // Coefficients of the approximation, scaled by 10^16.
    localparam logic [C2W-1:0] UN2 = 33'd1286412120;
    localparam logic [C1W-1:0] UN1 = 43'd1541182540000;
    localparam logic [DW-1:0]  UN0 = 61'd8601177570000000;
    localparam logic [C2W-1:0] UD2 = 33'd7081451630;
    localparam logic [C1W-1:0] UD1 = 43'd8424202350000;
    localparam logic [DW-1:0]  UD0 = 61'd10000000000000000;
    localparam logic [C2W-1:0] VN2 = 33'd420481691;
    localparam logic [C1W-1:0] VN1 = 43'd422806245000;
    localparam logic [DW-1:0]  VN0 = 61'd3173987260000000;
    localparam logic [C2W-1:0] VD2 = 33'd1614560530;
    localparam logic [C1W-1:0] VD1 = 43'd289741816000;
    localparam logic [DW-1:0]  VD0 = 61'd10000000000000000;

    // One coordinate in flight through the restoring divider.
    typedef struct packed {
        logic [DW-1:0] rem;
        logic [DW-1:0] den;
        logic [CW-1:0] quo;
    } t_div_lane;

endpackage

### hw/rtl/color_temperature_to_uv.sv
// Top level of the color temperature to CIE 1960 (u, v) converter.
// Depends on ctuv_pkg, ctuv_poly and ctuv_div_step.
//
//   Channel   Direction   Handshake             Payload
//   input     in          i_valid / o_stall     i_kelvin
//   output    out         o_valid / i_stall     o_u_coord, o_v_coord, o_out_of_range
//
// One word enters per cycle while o_stall is low; each word passes the Horner evaluation
// and then one divider step for each quotient bit of the restoring divider.
// Reset is synchronous and active low; it clears only the pipeline and skid valid bits.
// The whole pipeline advances together. A result that meets a stall at the output is parked
// in a one-word skid register, so the word behind it still moves up; o_stall is raised only
// while that register is full, and it comes straight from a flip-flop.
module color_temperature_to_uv import ctuv_pkg::*; #(
    parameter int FRAC_BITS = 20
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [KW-1:0]   i_kelvin,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [CW-1:0]   o_u_coord,
    output logic [CW-1:0]   o_v_coord,
    output logic            o_out_of_range
);

    // Stage 0 and 1 are the polynomial stages, stages 2 up to LAST are divider steps.
    localparam int NS   = FRAC_BITS + 2;
    localparam int LAST = NS - 1;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] r_oor;
    logic          w_en;
    logic          n_oor;

    logic          r_skid_vld;
    logic [CW-1:0] r_skid_u;
    logic [CW-1:0] r_skid_v;
    logic          r_skid_oor;

    t_div_lane     w_u_lane [FRAC_BITS+1];
    t_div_lane     w_v_lane [FRAC_BITS+1];

    // The pipeline moves whenever the skid register is free to catch a stalled result.
    assign w_en    = !r_skid_vld;
    assign o_stall = r_skid_vld;

    // Range check of the incoming word; both ends of the range are valid temperatures.
    assign n_oor = (i_kelvin < KELVIN_MIN) || (i_kelvin > KELVIN_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oor <= {r_oor[NS-2:0], n_oor};
        end
    end

    // Horner evaluation; the range flag of stage 0 zeroes the numerators.
    ctuv_poly u_poly (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_kelvin (i_kelvin),
        .i_oor    (r_oor[0]),
        .o_u_lane (w_u_lane[0]),
        .o_v_lane (w_v_lane[0])
    );

    // One divider step per fraction bit for each coordinate.
    for (genvar j = 0; j < FRAC_BITS; j++) begin : g_div
        ctuv_div_step u_div_u (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lane (w_u_lane[j]),
            .o_lane (w_u_lane[j+1])
        );
        ctuv_div_step u_div_v (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lane (w_v_lane[j]),
            .o_lane (w_v_lane[j+1])
        );
    end

    // Skid register: a finished word that is stalled while the pipeline moves is caught here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (w_en) begin
            r_skid_vld <= r_vld[LAST] && i_stall;
        end else if (!i_stall) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_skid_u   <= w_u_lane[FRAC_BITS].quo;
            r_skid_v   <= w_v_lane[FRAC_BITS].quo;
            r_skid_oor <= r_oor[LAST];
        end
    end

    // The skid register, when full, holds the older word and goes out first.
    assign o_valid        = r_skid_vld || r_vld[LAST];
    assign o_u_coord      = r_skid_vld ? r_skid_u   : w_u_lane[FRAC_BITS].quo;
    assign o_v_coord      = r_skid_vld ? r_skid_v   : w_v_lane[FRAC_BITS].quo;
    assign o_out_of_range = r_skid_vld ? r_skid_oor : r_oor[LAST];

    // An out-of-range word always leaves with zero coordinates.
    a_oor_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> (o_u_coord == '0) && (o_v_coord == '0))
        else $error("out-of-range word with nonzero coordinates");

    // While the skid register is full the pipeline must hold still.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |=> $stable(r_vld))
        else $error("pipeline moved while the skid register was full");

    // A stalled result in the last stage is caught by the skid register.
    a_catch : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_skid_vld && r_vld[LAST] && i_stall |=> r_skid_vld && o_stall)
        else $error("stalled result not caught by the skid register");

    // The divider remainder stays below the denominator for every valid word.
    a_rem : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] |-> (w_u_lane[FRAC_BITS].rem < w_u_lane[FRAC_BITS].den)
                     && (w_v_lane[FRAC_BITS].rem < w_v_lane[FRAC_BITS].den))
        else $error("divider remainder not below the denominator");

endmodule

### hw/rtl/ctuv_poly.sv
// Two-stage Horner evaluation of the four quadratics in kelvin.
// Depends on ctuv_pkg for the coefficients and the divider lane type.
module ctuv_poly import ctuv_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [KW-1:0]   i_kelvin,
    input  logic            i_oor,
    output t_div_lane       o_u_lane,
    output t_div_lane       o_v_lane
);

    // First stage: the inner Horner steps; the v denominator is split into two parts.
    logic [KW-1:0] r_t;
    logic [AW-1:0] r_un_a, r_ud_a, r_vn_a, r_vd_p;
    logic [DW-1:0] r_vd_m;
    logic [AW-1:0] n_un_a, n_ud_a, n_vn_a, n_vd_p;
    logic [DW-1:0] n_vd_m;

    always_comb begin
        n_un_a = AW'(UN2) * AW'(i_kelvin) + AW'(UN1);
        n_ud_a = AW'(UD2) * AW'(i_kelvin) + AW'(UD1);
        n_vn_a = AW'(VN2) * AW'(i_kelvin) + AW'(VN1);
        // The v denominator has a negative linear term; it stays below the constant term.
        n_vd_p = AW'(VD2) * AW'(i_kelvin);
        n_vd_m = VD0 - DW'(VD1) * DW'(i_kelvin);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= i_kelvin;
            r_un_a <= n_un_a;
            r_ud_a <= n_ud_a;
            r_vn_a <= n_vn_a;
            r_vd_p <= n_vd_p;
            r_vd_m <= n_vd_m;
        end
    end

    // Second stage: the outer Horner step. An out-of-range word gets a zero numerator,
    // so the divider returns zero coordinates for it.
    logic [PW-1:0] w_un, w_ud, w_vn, w_vd;
    t_div_lane     n_u_lane, n_v_lane;
    t_div_lane     r_u_lane, r_v_lane;

    always_comb begin
        w_un = PW'(r_un_a) * PW'(r_t) + PW'(UN0);
        w_ud = PW'(r_ud_a) * PW'(r_t) + PW'(UD0);
        w_vn = PW'(r_vn_a) * PW'(r_t) + PW'(VN0);
        w_vd = PW'(r_vd_p) * PW'(r_t) + PW'(r_vd_m);

        n_u_lane.rem = i_oor ? '0 : w_un[DW-1:0];
        n_u_lane.den = w_ud[DW-1:0];
        n_u_lane.quo = '0;
        n_v_lane.rem = i_oor ? '0 : w_vn[DW-1:0];
        n_v_lane.den = w_vd[DW-1:0];
        n_v_lane.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u_lane <= n_u_lane;
            r_v_lane <= n_v_lane;
        end
    end

    assign o_u_lane = r_u_lane;
    assign o_v_lane = r_v_lane;

endmodule

### hw/rtl/ctuv_div_step.sv
// One registered step of the restoring fraction divider: one quotient bit per stage.
// Depends on ctuv_pkg for the lane type and widths.
module ctuv_div_step import ctuv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_div_lane   i_lane,
    output t_div_lane   o_lane
);

    logic [DW:0] w_rem2;
    logic [DW:0] w_diff;
    logic        w_ge;
    t_div_lane   n_lane;
    t_div_lane   r_lane;

    // The remainder stays below the denominator, so the doubled value fits one more bit
    // and the top bit of the difference tells whether the subtraction goes through.
    always_comb begin
        w_rem2      = {i_lane.rem, 1'b0};
        w_diff      = w_rem2 - {1'b0, i_lane.den};
        w_ge        = !w_diff[DW];
        n_lane.rem  = w_ge ? w_diff[DW-1:0] : w_rem2[DW-1:0];
        n_lane.den  = i_lane.den;
        n_lane.quo  = {i_lane.quo[CW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

### dv/ctuv_checker.sv
`timescale 1ns / 100ps
// Checker for the color temperature to (u, v) converter: predicts each result word.
// Watches both channels and compares results in order. Needs ctuv_pkg for field widths.
module ctuv_checker import ctuv_pkg::*; #(
    parameter int FRAC_BITS = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  logic [KW-1:0] i_kelvin,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  logic [CW-1:0] i_u_coord,
    input  logic [CW-1:0] i_v_coord,
    input  logic          i_out_of_range,
    output int            o_errors,
    output int            o_pending,
    output int            o_results
);

    localparam int REPORT_MAX = 10;

    // Krystek coefficients scaled by 1e16 so that all four quadratics stay exact integers.
    localparam logic [63:0] U_NUM2 = 64'd1286412120;
    localparam logic [63:0] U_NUM1 = 64'd1541182540000;
    localparam logic [63:0] U_NUM0 = 64'd8601177570000000;
    localparam logic [63:0] U_DEN2 = 64'd7081451630;
    localparam logic [63:0] U_DEN1 = 64'd8424202350000;
    localparam logic [63:0] U_DEN0 = 64'd10000000000000000;
    localparam logic [63:0] V_NUM2 = 64'd420481691;
    localparam logic [63:0] V_NUM1 = 64'd422806245000;
    localparam logic [63:0] V_NUM0 = 64'd3173987260000000;
    localparam logic [63:0] V_DEN2 = 64'd1614560530;
    localparam logic [63:0] V_DEN1 = 64'd289741816000;
    localparam logic [63:0] V_DEN0 = 64'd10000000000000000;

    typedef struct packed {
        logic [KW-1:0] kelvin;
        logic [CW-1:0] u;
        logic [CW-1:0] v;
        logic          oor;
    } t_locus_word;

    t_locus_word locus_q [$];

    // floor(num * 2^FRAC_BITS / den), kept to the coordinate width.
    function automatic logic [CW-1:0] scaled_ratio(input logic [63:0] num,
                                                   input logic [63:0] den);
        logic [127:0] quo;
        quo = ({64'd0, num} << FRAC_BITS) / {64'd0, den};
        return quo[CW-1:0];
    endfunction

    function automatic t_locus_word locus_point(input logic [KW-1:0] kelvin);
        t_locus_word w;
        logic [63:0] t, un, ud, vn, vd;
        w.kelvin = kelvin;
        if (kelvin < 14'd1000 || kelvin > 14'd15000) begin
            w.u   = '0;
            w.v   = '0;
            w.oor = 1'b1;
        end else begin
            t  = {50'd0, kelvin};
            un = (U_NUM2 * t + U_NUM1) * t + U_NUM0;
            ud = (U_DEN2 * t + U_DEN1) * t + U_DEN0;
            vn = (V_NUM2 * t + V_NUM1) * t + V_NUM0;
            // The linear term of the v denominator is negative; it never exceeds the constant.
            vd = (V_DEN2 * t) * t + (V_DEN0 - V_DEN1 * t);
            w.u   = scaled_ratio(un, ud);
            w.v   = scaled_ratio(vn, vd);
            w.oor = 1'b0;
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_locus_word exp_w;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_pending <= 0;
            o_results <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (locus_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < REPORT_MAX)
                        $display("%0t: unexpected result word u=%0h v=%0h oor=%0b",
                                 $realtime, i_u_coord, i_v_coord, i_out_of_range);
                end else begin
                    exp_w = locus_q.pop_front();
                    if (i_u_coord !== exp_w.u || i_v_coord !== exp_w.v ||
                        i_out_of_range !== exp_w.oor) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < REPORT_MAX)
                            $display({"%0t: kelvin %0d expected u=%0h v=%0h oor=%0b,",
                                      " got u=%0h v=%0h oor=%0b"},
                                     $realtime, exp_w.kelvin, exp_w.u, exp_w.v, exp_w.oor,
                                     i_u_coord, i_v_coord, i_out_of_range);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                locus_q.push_back(locus_point(i_kelvin));
            o_pending <= locus_q.size();
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Top of the testbench for color_temperature_to_uv: clock, reset, stimulus and verdict.
// Depends on ctuv_pkg, the converter itself and ctuv_checker.
module tb_top;
    import ctuv_pkg::*;

    localparam int FRAC_BITS    = 20;
    localparam int LATENCY      = FRAC_BITS + 2;
    // Number of random words in each of the three idle/stall mixes.
    localparam int RAND_PER_MIX = 544;
    // Length of the single long output hold-off, long enough to fill the pipeline.
    localparam int HOLD_CYCLES  = 200;
    // Cycles without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 3 * LATENCY + 10;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic [KW-1:0] i_kelvin;
    logic          o_valid;
    logic          i_stall;
    logic [CW-1:0] o_u_coord;
    logic [CW-1:0] o_v_coord;
    logic          o_out_of_range;

    int errors;
    int pending;
    int results;
    int mix;          // 0: sender 37 / receiver 71, 1: the other way round, 2: no idling
    int sent;
    int oor_sent;
    int quiet;
    bit hold_done;

    // Corner temperatures: both range ends and their neighbors, the field extremes,
    // and a few points across the valid span.
    int corners [$] = '{0, 1, 999, 1000, 1001, 1500, 2000, 4000, 6500, 8191, 8192,
                        10000, 12345, 14999, 15000, 15001, 16382, 16383};

    always #2 i_clk = ~i_clk;

    color_temperature_to_uv #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kelvin       (i_kelvin),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_u_coord      (o_u_coord),
        .o_v_coord      (o_v_coord),
        .o_out_of_range (o_out_of_range)
    );

    ctuv_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) locus_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_kelvin       (i_kelvin),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_u_coord      (o_u_coord),
        .i_v_coord      (o_v_coord),
        .i_out_of_range (o_out_of_range),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_results      (results)
    );

    // Receiver side. The stall rate follows the current mix. When the last mix begins,
    // the output is held off once for a long stretch while the sender keeps offering
    // words, so the pipeline and its skid register fill and the input stall shows up.
    // Each edge carries exactly one assignment to i_stall.
    initial begin
        i_stall   = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (mix == 2 && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            case (mix)
                0: begin
                    i_stall <= ($urandom_range(99) < 71);
                end
                1: begin
                    i_stall <= ($urandom_range(99) < 37);
                end
                default: begin
                    i_stall <= 1'b0;
                end
            endcase
        end
    end

    // Watchdog: any cycle with a handshake on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet <= 0;
        end else if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Mostly valid temperatures, with a share of words below and above the range
    // and a cluster right around both range ends.
    function automatic logic [KW-1:0] pick_kelvin();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return KW'($urandom_range(999, 0));
        else if (r < 16)
            return KW'($urandom_range(16383, 15001));
        else if (r < 22)
            return $urandom_range(1) ? KW'($urandom_range(1003, 997))
                                     : KW'($urandom_range(15003, 14997));
        else
            return KW'($urandom_range(15000, 1000));
    endfunction

    // Offers one word. Before it, the sender idles for a random number of cycles
    // depending on idle_pct; valid is only lowered when at least one idle edge
    // follows, so it is never dropped and raised in the same step. The word then
    // stays on the bus unchanged until it is taken.
    task automatic offer_kelvin(input logic [KW-1:0] kelvin, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_kelvin <= kelvin;
        sent++;
        if (kelvin < 14'd1000 || kelvin > 14'd15000)
            oor_sent++;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin
        int idle_pct;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_kelvin = '0;
        mix      = 0;
        sent     = 0;
        oor_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners go through under the first mix.
        foreach (corners[i])
            offer_kelvin(KW'(corners[i]), 37);

        for (int m = 0; m < 3; m++) begin
            mix = m;
            idle_pct = (m == 0) ? 37 : (m == 1) ? 71 : 0;
            repeat (RAND_PER_MIX)
                offer_kelvin(pick_kelvin(), idle_pct);
        end
        i_valid <= 1'b0;

        // Let the pipeline empty, then give stray words a chance to appear.
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d kelvin words (%0d outside 1000..15000), %0d results checked,",
                 sent, oor_sent, results);
        $display("summary: three idle/stall mixes and one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (errors == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
